@@ rtl/core/ordered_list_positional_delete_core_assert.svh @@
// Assertion macros for the ordered list core.
// Expects signals clk and arst_n in the scope of each use.
`ifndef ORDERED_LIST_POSITIONAL_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_POSITIONAL_DELETE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OLPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("olpd assertion failed");
`define OLPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("olpd assertion failed");
`else
`define OLPD_ASSERT(lbl, prop)
`define OLPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/olpd_pkg.sv @@
// Shared types and constants of the ordered list core.
// No dependencies.
package olpd_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND    = 2'd0,
		ACT_DEL_FIRST = 2'd1,
		ACT_DEL_LAST  = 2'd2,
		ACT_DEL_POS   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic append_en;
		logic remove_en;
	} cell_ctl_t;

endpackage

@@ rtl/core/olpd_if.sv @@
// Request and response channel interfaces of the ordered list core.
// Depends on olpd_pkg for field widths.
interface olpd_req_if;
	logic                                valid;
	logic                                ready;
	logic [olpd_pkg::ACTION_W-1:0]       action;
	logic signed [olpd_pkg::VALUE_W-1:0] value;
	logic [olpd_pkg::POS_W-1:0]          position;

	modport source (output valid, output action, output value, output position, input ready);
	modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface olpd_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [olpd_pkg::VALUE_W-1:0] removed_value;
	logic [olpd_pkg::STATUS_W-1:0]       status;
	logic [olpd_pkg::COUNT_W-1:0]        entry_count;

	modport source (output valid, output removed_value, output status, output entry_count,
		input ready);
	modport sink   (input valid, input removed_value, input status, input entry_count,
		output ready);
endinterface

@@ rtl/core/olpd_cell.sv @@
// One storage cell of the list chain: holds one entry, loads on append,
// takes its right neighbor's entry when a removal closes the gap.
// Depends on olpd_pkg.
module olpd_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4,
	parameter int CW  = 5
) (
	input  logic                                clk,
	input  olpd_pkg::cell_ctl_t                 ctl,
	input  logic [IW-1:0]                       target,
	input  logic [CW-1:0]                       count,
	input  logic signed [olpd_pkg::VALUE_W-1:0] value,
	input  logic signed [olpd_pkg::VALUE_W-1:0] next_data,
	output logic signed [olpd_pkg::VALUE_W-1:0] data,
	output logic signed [olpd_pkg::VALUE_W-1:0] tap
);
	import olpd_pkg::*;

	logic signed [VALUE_W-1:0] data_q;
	logic                      load;
	logic                      shift;
	logic                      hit;

	// Decode this cell's role for the current request
	always_comb begin
		load  = ctl.append_en && (count == CW'(IDX));
		hit   = ctl.remove_en && (target == IW'(IDX));
		shift = ctl.remove_en && (target <= IW'(IDX)) && (CW'(IDX + 1) < count);
	end

	// Hold, load the appended value, or advance the neighbor's entry
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= value;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;
	assign tap  = hit ? data_q : '0;

endmodule

@@ rtl/core/ordered_list_positional_delete_core.sv @@
// Ordered list core: a row of storage cells with append and removals.
// Depends on olpd_pkg, olpd_if, olpd_cell and the assertion header.
//
// Usage:
//   req carries one command per request: action (append, remove first,
//   remove last, remove at 1-based position), value for appends, and
//   position for positional removals. rsp returns one result per request:
//   the removed value (zero unless a removal succeeded), a status (ok,
//   missing, full) and the entry count after the command.
//   The result is registered and appears on rsp in the cycle after the
//   request is taken. Throughput: one request per cycle while rsp is
//   drained. Every cell compares its own index with the target slot
//   and the count, so a removal shifts all later entries one place left
//   in the same cycle; the removed value is an OR of the cells' taps.
//   The response sits in a single output register; req.ready is high while
//   that register is empty or being drained, so a stalled receiver holds
//   the result and stops new requests after one.
//   Reset (arst_n low) empties the list and drops any pending result; the
//   entries themselves are not cleared, only the count.
`include "ordered_list_positional_delete_core_assert.svh"

module ordered_list_positional_delete_core #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	olpd_req_if.sink   req,
	olpd_rsp_if.source rsp
);
	import olpd_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]             count_q;
	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] removed_q;
	status_t                   status_q;
	logic [COUNT_W-1:0]        entry_count_q;

	logic                      acc;
	logic                      empty;
	logic                      full;
	action_t                   act;
	logic [PW-1:0]             pos_w;
	logic [PW-1:0]             cnt_w;
	logic [CW-1:0]             last_idx;
	logic [IW-1:0]             target;
	logic                      rm_ok;
	cell_ctl_t                 ctl;
	status_t                   status_d;
	logic [CW-1:0]             count_d;
	logic signed [VALUE_W-1:0] removed_d;

	logic signed [VALUE_W-1:0] cell_data [DEPTH];
	logic signed [VALUE_W-1:0] cell_tap  [DEPTH];

	assign acc       = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign act       = action_t'(req.action);
	assign pos_w     = PW'(req.position);
	assign cnt_w     = PW'(count_q);
	assign last_idx  = count_q - CW'(1);

	// Decode the request into target slot, cell controls and status
	always_comb begin
		target   = '0;
		rm_ok    = 1'b0;
		ctl      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (act)
			ACT_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.append_en = acc;
					count_d       = count_q + CW'(1);
				end
			end
			ACT_DEL_FIRST: begin
				rm_ok = !empty;
			end
			ACT_DEL_LAST: begin
				rm_ok  = !empty;
				target = IW'(last_idx);
			end
			ACT_DEL_POS: begin
				rm_ok  = !empty && (pos_w != '0) && (pos_w <= cnt_w);
				target = IW'(pos_w - PW'(1));
			end
			default: begin
				status_d = ST_MISSING;
			end
		endcase
		if (act != ACT_APPEND) begin
			if (rm_ok) begin
				ctl.remove_en = acc;
				count_d       = count_q - CW'(1);
			end else begin
				status_d = ST_MISSING;
			end
		end
	end

	// Chain of cells; the last cell has no right neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VALUE_W-1:0] nbr;
		if (g == DEPTH - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[g+1];
		end
		olpd_cell #(
			.IDX (g),
			.IW  (IW),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.target    (target),
			.count     (count_q),
			.value     (req.value),
			.next_data (nbr),
			.data      (cell_data[g]),
			.tap       (cell_tap[g])
		);
	end

	// Collect the removed entry from the one cell that is hit
	always_comb begin
		removed_d = '0;
		for (int k = 0; k < DEPTH; k++) begin
			removed_d = removed_d | cell_tap[k];
		end
	end

	// Update the count on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_d;
		end
	end

	// Hold the response until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			removed_q     <= removed_d;
			status_q      <= status_d;
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.entry_count   = entry_count_q;

	// Checks on the list bookkeeping
	`OLPD_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`OLPD_ASSERT_NEXT(a_full_append, acc && act == ACT_APPEND && full,
		rsp.status == ST_FULL && $stable(count_q))
	`OLPD_ASSERT_NEXT(a_remove_dec, ctl.remove_en,
		count_q == $past(count_q) - CW'(1) && rsp.status == ST_OK)

endmodule
